FILE: rtl/ll1p_pkg.sv
`default_nettype none
package ll1p_pkg;

  // Operation codes of an input beat
  localparam logic [2:0] OP_SET_NT  = 3'd0;
  localparam logic [2:0] OP_SET_T   = 3'd1;
  localparam logic [2:0] OP_PROD    = 3'd2;
  localparam logic [2:0] OP_START   = 3'd3;
  localparam logic [2:0] OP_TOKEN   = 3'd4;

  // Result action codes
  localparam logic [1:0] ACT_APPLY  = 2'd0;
  localparam logic [1:0] ACT_MATCH  = 2'd1;
  localparam logic [1:0] ACT_ACCEPT = 2'd2;
  localparam logic [1:0] ACT_ERROR  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MISMATCH = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW = 3'd3;
  localparam logic [2:0] ERR_EXPLIMIT = 3'd4;
  localparam logic [2:0] ERR_NOTPARSE = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_NT_COUNT = 2'd0;
  localparam logic [1:0] CFG_T_COUNT  = 2'd1;

  // Special symbols
  localparam logic [7:0] END_MARK = 8'h24;
  localparam logic [7:0] EPS_CHAR = 8'h65;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] row_index;
    logic [3:0] column_index;
    logic [3:0] char_position;
    logic [4:0] prod_length;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action_kind;
    logic [3:0] applied_row;
    logic [3:0] applied_column;
    logic [2:0] error_kind;
    logic [6:0] stack_level;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ_TOP,
    S_LOOKUP,
    S_DECIDE,
    S_LENGTH,
    S_PUSH,
    S_APPLY
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       take;
    logic       start_top;
    logic       rd_top;
    logic       lookup;
    logic       rd_cell;
    logic       expand;
    logic       push;
    logic       emit;
    logic       pop;
    logic       finish;
    logic       count_exp;
    logic [1:0] kind;
    logic [2:0] err;
    logic       last;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] in_op;
    logic       active;
    logic       stack_empty;
    logic       is_accept;
    logic       nt_found;
    logic       top_eq_sym;
    logic       t_found;
    logic       at_limit;
    logic       overflow;
    logic       len_zero;
    logic       push_last;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/ll1p_ctrl.sv
`default_nettype none
module ll1p_ctrl
  import ll1p_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.in_op == OP_START) begin
            state_next = S_START;
          end else if (status.in_op == OP_TOKEN) begin
            state_next = S_READ_TOP;
          end
        end
      end
      S_START: state_next = S_IDLE;
      S_READ_TOP: begin
        if (!status.active || status.stack_empty) begin
          if (status.out_free) state_next = S_IDLE;
        end else begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: state_next = S_DECIDE;
      S_DECIDE: begin
        if (status.is_accept || !status.nt_found || !status.t_found || status.at_limit) begin
          if (status.out_free) state_next = S_IDLE;
        end else begin
          state_next = S_LENGTH;
        end
      end
      S_LENGTH: begin
        if (status.overflow) begin
          if (status.out_free) state_next = S_IDLE;
        end else if (status.len_zero) begin
          state_next = S_APPLY;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: if (status.push_last) state_next = S_APPLY;
      S_APPLY: if (status.out_free) state_next = S_READ_TOP;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.kind = ACT_ERROR;
    cmd.err  = ERR_NONE;
    cmd.last = 1'b1;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_START: cmd.start_top = 1'b1;
      S_READ_TOP: begin
        if (!status.active) begin
          cmd.emit = status.out_free;
          cmd.err  = ERR_NOTPARSE;
        end else if (status.stack_empty) begin
          cmd.emit   = status.out_free;
          cmd.finish = status.out_free;
          cmd.err    = ERR_MISMATCH;
        end else begin
          cmd.rd_top = 1'b1;
        end
      end
      S_LOOKUP: cmd.lookup = 1'b1;
      S_DECIDE: begin
        if (status.is_accept) begin
          cmd.emit   = status.out_free;
          cmd.finish = status.out_free;
          cmd.kind   = ACT_ACCEPT;
        end else if (!status.nt_found) begin
          cmd.emit = status.out_free;
          if (status.top_eq_sym) begin
            cmd.kind = ACT_MATCH;
            cmd.pop  = status.out_free;
          end else begin
            cmd.err    = ERR_MISMATCH;
            cmd.finish = status.out_free;
          end
        end else if (!status.t_found) begin
          cmd.emit   = status.out_free;
          cmd.finish = status.out_free;
          cmd.err    = ERR_UNKNOWN;
        end else if (status.at_limit) begin
          cmd.emit   = status.out_free;
          cmd.finish = status.out_free;
          cmd.err    = ERR_EXPLIMIT;
        end else begin
          cmd.rd_cell = 1'b1;
        end
      end
      S_LENGTH: begin
        if (status.overflow) begin
          cmd.emit   = status.out_free;
          cmd.finish = status.out_free;
          cmd.err    = ERR_OVERFLOW;
        end else begin
          cmd.expand = 1'b1;
        end
      end
      S_PUSH: cmd.push = 1'b1;
      S_APPLY: begin
        cmd.emit      = status.out_free;
        cmd.count_exp = status.out_free;
        cmd.kind      = ACT_APPLY;
        cmd.last      = 1'b0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ll1p_datapath.sv
`default_nettype none
module ll1p_datapath
  import ll1p_pkg::*;
#(
  parameter int NT_MAX      = 16,
  parameter int T_MAX       = 16,
  parameter int PROD_MAX    = 16,
  parameter int STACK_DEPTH = 64,
  parameter int EXP_LIMIT   = 15
) (
  input  wire        clk,
  input  wire        rst,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_item,
  input  wire        cfg_write,
  input  wire  [1:0] cfg_index,
  input  wire  [4:0] cfg_data,
  input  ctl_cmd_t   cmd,
  output dp_status_t status
);

  localparam int NW    = (NT_MAX > 1) ? $clog2(NT_MAX) : 1;
  localparam int TW    = (T_MAX > 1) ? $clog2(T_MAX) : 1;
  localparam int CELLS = NT_MAX * T_MAX;
  localparam int CLW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CHARS = CELLS * PROD_MAX;
  localparam int CHW   = (CHARS > 1) ? $clog2(CHARS) : 1;
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int LW    = $clog2(PROD_MAX + 1);
  localparam int EW    = $clog2(EXP_LIMIT + 1);

  logic [4:0]     nt_count;
  logic [4:0]     t_count;
  logic [7:0]     nt_sym [NT_MAX];
  logic [7:0]     t_sym [T_MAX];
  logic [7:0]     char_mem [CHARS];
  logic [LW-1:0]  len_mem [CELLS];
  logic [CELLS-1:0] len_valid;
  logic [7:0]     stack_mem [STACK_DEPTH];
  logic [CW-1:0]  stack_count;
  logic           active;
  logic [7:0]     tok_sym;
  logic [EW-1:0]  exps;
  logic [7:0]     top_sym;
  logic           nt_found;
  logic [NW-1:0]  nt_idx;
  logic           t_found;
  logic [TW-1:0]  t_idx;
  logic           accept_hit;
  logic           top_eq;
  logic [LW-1:0]  len_rd;
  logic           len_ok;
  logic [7:0]     char_rd;
  logic [LW-1:0]  push_i;

  // Combinational lookup and address terms
  logic           nt_hit;
  logic [NW-1:0]  nt_hit_idx;
  logic           t_hit;
  logic [TW-1:0]  t_hit_idx;
  logic [CLW-1:0] cell_sel;
  logic [CHW-1:0] base_sel;
  logic [CLW-1:0] ld_cell;
  logic [CHW-1:0] ld_addr;
  logic           ld_ok;
  logic [LW-1:0]  ld_len;
  logic [LW-1:0]  len_eff;
  logic           take_op3;
  logic           take_op4;

  assign take_op3 = cmd.take && (in_item.operation == OP_START);
  assign take_op4 = cmd.take && (in_item.operation == OP_TOKEN);

  // Priority search, lowest index wins
  always_comb begin
    nt_hit     = 1'b0;
    nt_hit_idx = '0;
    for (int i = NT_MAX - 1; i >= 0; i--) begin
      if (i < int'(nt_count) && nt_sym[i] == top_sym) begin
        nt_hit     = 1'b1;
        nt_hit_idx = NW'(i);
      end
    end
    t_hit     = 1'b0;
    t_hit_idx = '0;
    for (int j = T_MAX - 1; j >= 0; j--) begin
      if (j < int'(t_count) && t_sym[j] == tok_sym) begin
        t_hit     = 1'b1;
        t_hit_idx = TW'(j);
      end
    end
  end

  assign cell_sel = CLW'(CLW'(nt_idx) * CLW'(T_MAX) + CLW'(t_idx));
  assign base_sel = CHW'(CHW'(cell_sel) * CHW'(PROD_MAX));
  assign ld_cell  = CLW'(CLW'(in_item.row_index) * CLW'(T_MAX) + CLW'(in_item.column_index));
  assign ld_addr  = CHW'(CHW'(ld_cell) * CHW'(PROD_MAX) + CHW'(in_item.char_position));
  assign ld_ok    = (int'(in_item.row_index) < NT_MAX) && (int'(in_item.column_index) < T_MAX)
                    && (int'(in_item.char_position) < PROD_MAX);
  assign ld_len   = (int'(in_item.prod_length) > PROD_MAX) ? LW'(PROD_MAX)
                                                           : LW'(in_item.prod_length);

  // Epsilon: length one holding 'e'
  always_comb begin
    len_eff = len_ok ? len_rd : '0;
    if (len_eff == LW'(1) && char_rd == EPS_CHAR) len_eff = '0;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nt_count <= 5'd1;
      t_count  <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NT_COUNT: nt_count <= cfg_data;
        CFG_T_COUNT:  t_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Symbol lists
  always_ff @(posedge clk) begin
    if (cmd.take && in_item.operation == OP_SET_NT && int'(in_item.row_index) < NT_MAX) begin
      nt_sym[NW'(in_item.row_index)] <= in_item.symbol;
    end
    if (cmd.take && in_item.operation == OP_SET_T && int'(in_item.column_index) < T_MAX) begin
      t_sym[TW'(in_item.column_index)] <= in_item.symbol;
    end
  end

  // Production character memory
  always_ff @(posedge clk) begin
    if (cmd.take && in_item.operation == OP_PROD && ld_ok) begin
      char_mem[ld_addr] <= in_item.symbol;
    end
    if (cmd.rd_cell) begin
      char_rd <= char_mem[base_sel];
    end else if (cmd.expand && len_eff != '0) begin
      char_rd <= char_mem[CHW'(base_sel + CHW'(len_eff) - CHW'(1))];
    end else if (cmd.push && push_i != '0) begin
      char_rd <= char_mem[CHW'(base_sel + CHW'(push_i) - CHW'(1))];
    end
  end

  // Production length memory
  always_ff @(posedge clk) begin
    if (cmd.take && in_item.operation == OP_PROD && ld_ok) begin
      len_mem[ld_cell] <= ld_len;
    end
    if (cmd.rd_cell) begin
      len_rd <= len_mem[cell_sel];
    end
  end

  // Length valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= '0;
      len_ok    <= 1'b0;
    end else begin
      if (cmd.take && in_item.operation == OP_PROD && ld_ok) len_valid[ld_cell] <= 1'b1;
      if (cmd.rd_cell) len_ok <= len_valid[cell_sel];
    end
  end

  // Symbol stack memory
  always_ff @(posedge clk) begin
    if (take_op3) begin
      stack_mem[SAW'(0)] <= END_MARK;
    end else if (cmd.start_top) begin
      stack_mem[SAW'(1)] <= nt_sym[0];
    end else if (cmd.push) begin
      stack_mem[stack_count[SAW-1:0]] <= char_rd;
    end
    if (cmd.rd_top) begin
      top_sym <= stack_mem[SAW'(stack_count - CW'(1))];
    end
  end

  // Stack count and parse control
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      active      <= 1'b0;
    end else begin
      if (take_op3) begin
        stack_count <= CW'(1);
        active      <= 1'b1;
      end else if (cmd.start_top) begin
        stack_count <= CW'(2);
      end else if (cmd.pop || cmd.expand) begin
        stack_count <= stack_count - CW'(1);
      end else if (cmd.push) begin
        stack_count <= stack_count + CW'(1);
      end
      if (cmd.finish) active <= 1'b0;
    end
  end

  // Token working registers
  always_ff @(posedge clk) begin
    if (take_op4) begin
      tok_sym <= in_item.symbol;
      exps    <= '0;
    end else if (cmd.count_exp) begin
      exps <= exps + EW'(1);
    end
    if (cmd.lookup) begin
      nt_found   <= nt_hit;
      nt_idx     <= nt_hit_idx;
      t_found    <= t_hit;
      t_idx      <= t_hit_idx;
      accept_hit <= (top_sym == END_MARK) && (tok_sym == END_MARK);
      top_eq     <= (top_sym == tok_sym);
    end
    if (cmd.expand) begin
      push_i <= (len_eff != '0) ? LW'(len_eff - LW'(1)) : '0;
    end else if (cmd.push && push_i != '0) begin
      push_i <= push_i - LW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.action_kind    <= cmd.kind;
      out_item.applied_row    <= (cmd.kind == ACT_APPLY) ? 4'(nt_idx) : 4'd0;
      out_item.applied_column <= (cmd.kind == ACT_APPLY) ? 4'(t_idx) : 4'd0;
      out_item.error_kind     <= cmd.err;
      out_item.stack_level    <= cmd.pop ? 7'(stack_count - CW'(1)) : 7'(stack_count);
      out_item.last_of_run    <= cmd.last;
    end
  end

  // Status
  assign status.in_op       = in_item.operation;
  assign status.active      = active;
  assign status.stack_empty = (stack_count == '0);
  assign status.is_accept   = accept_hit;
  assign status.nt_found    = nt_found;
  assign status.top_eq_sym  = top_eq;
  assign status.t_found     = t_found;
  assign status.at_limit    = (int'(exps) >= EXP_LIMIT);
  assign status.overflow    = (int'(stack_count) - 1 + int'(len_eff)) > STACK_DEPTH;
  assign status.len_zero    = (len_eff == '0);
  assign status.push_last   = (push_i == '0);
  assign status.out_free    = !out_valid || out_ready;

endmodule
`default_nettype wire

FILE: rtl/ll1_table_driven_parser.sv
// LL(1) table-driven predictive parser.
// Input channel (in_valid/in_ready/in_item) carries load, start and token beats.
// Load beats fill the symbol lists and production cells; a start beat
// passes through S_START and resets the stack to '$' and the first
// nonterminal. Only token beats produce results on the output channel
// (out_valid/out_ready/out_item): zero or more apply beats, then one final
// match, accept or error beat flagged by last_of_run.
// A token reads the stack top in S_READ_TOP, looks it up in S_LOOKUP and
// decides in S_DECIDE; with no parse active or an empty stack it ends in
// S_READ_TOP. Each expansion passes S_LENGTH, S_PUSH (skipped for an empty
// production) and S_APPLY, the production character memory delivering one
// character a cycle to the stack memory. At most EXP_LIMIT expansions per token.
// The config port (cfg_write/cfg_index/cfg_data) sets the nonterminal and
// terminal counts; write it only while the parser is idle.
// Reset (rst, synchronous) empties the stack, ends any parse, marks all
// production cells empty and restores both counts to 1.
// One output register holds a result beat; when the receiver stalls the
// parser holds its state until the register frees, while load beats are
// still accepted between tokens.
`default_nettype none
module ll1_table_driven_parser
  import ll1p_pkg::*;
#(
  parameter int NT_MAX      = 16,
  parameter int T_MAX       = 16,
  parameter int PROD_MAX    = 16,
  parameter int STACK_DEPTH = 64,
  parameter int EXP_LIMIT   = 15
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_item,
  input  wire        cfg_write,
  input  wire  [1:0] cfg_index,
  input  wire  [4:0] cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  ll1p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ll1p_datapath #(
    .NT_MAX      (NT_MAX),
    .T_MAX       (T_MAX),
    .PROD_MAX    (PROD_MAX),
    .STACK_DEPTH (STACK_DEPTH),
    .EXP_LIMIT   (EXP_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

FILE: rtl/ll1p_checker.sv
`default_nettype none
module ll1p_checker
  import ll1p_pkg::*;
(
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input out_item_t out_item
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // Apply beats never close a run, all others do
  a_apply_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.action_kind == ACT_APPLY) != out_item.last_of_run))
    else $error("last_of_run inconsistent with action");

  // Error code present exactly on error beats
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.action_kind == ACT_ERROR) == (out_item.error_kind != ERR_NONE)))
    else $error("error_kind inconsistent with action");

  // Cell coordinates only on apply beats
  a_cell_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.action_kind != ACT_APPLY
      |-> out_item.applied_row == 4'd0 && out_item.applied_column == 4'd0)
    else $error("cell coordinates on non-apply beat");

endmodule

bind ll1_table_driven_parser ll1p_checker u_ll1p_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
